[design/teq_pkg.sv]
// ----------------------------------------------------------------------------
// Timer expiry queue package
// Shared types and command codes for the timer expiry queue.
// ----------------------------------------------------------------------------
package teq_pkg;

   localparam int TIME_W = 48;
   localparam int ID_W   = 32;
   localparam int HND_W  = 32;
   localparam int ORD_W  = 32;
   localparam int CMD_W  = 2;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   // One timer entry as it is kept in the slot memory.
   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] period;
      logic [ID_W-1:0]   id;
      logic [HND_W-1:0]  handle;
      logic [ORD_W-1:0]  order;
   } slot_type;

   // Control of the scan unit from the sequencer.
   typedef struct packed {
      logic clr;
      logic cand_vld;
      logic match_id;
   } scan_ctl_type;

endpackage

[design/teq_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module teq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/teq_scan.sv]
// ----------------------------------------------------------------------------
// Timer expiry queue scan unit
// Shared compare unit that keeps the earliest eligible entry seen in a scan.
// ----------------------------------------------------------------------------
module teq_scan #(
   parameter int SLOTS = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  teq_pkg::scan_ctl_type                       ctl,
   input  logic [teq_pkg::ID_W-1:0]                    target_id,
   input  teq_pkg::slot_type                           cand,
   input  logic                                        cand_live,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] cand_idx,
   output logic                                        best_found,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] best_idx,
   output teq_pkg::slot_type                           best
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KEY_W = teq_pkg::TIME_W + teq_pkg::ORD_W;

   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   teq_pkg::slot_type    best_ff, best_in;
   logic                 eligible;
   logic                 earlier;
   logic [KEY_W-1:0]     cand_key;
   logic [KEY_W-1:0]     best_key;

   // Deadline first; among equal deadlines the lower order stamp wins.
   assign cand_key = {cand.deadline, cand.order};
   assign best_key = {best_ff.deadline, best_ff.order};
   assign earlier  = cand_key < best_key;
   assign eligible = ctl.cand_vld && cand_live && (!ctl.match_id || cand.id == target_id);

   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      best_in  = best_ff;
      if (ctl.clr) begin
         found_in = 1'b0;
      end else if (eligible && (!found_ff || earlier)) begin
         found_in = 1'b1;
         idx_in   = cand_idx;
         best_in  = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff  <= idx_in;
      best_ff <= best_in;
   end

   assign best_found = found_ff;
   assign best_idx   = idx_ff;
   assign best       = best_ff;

endmodule

[design/timer_expiry_queue_unit.sv]
// ----------------------------------------------------------------------------
// Timer expiry queue unit
// Table of software timers with add, remove and tick commands.
// ----------------------------------------------------------------------------
// The block keeps up to SLOTS timers in a slot memory and takes one command
// transaction at a time: add stores a timer in the lowest free slot and hands
// out the next id, remove deletes the earliest timer with a given id, and tick
// fires the earliest timer whose deadline has passed, re-arming it at now plus
// its period or freeing it when it is one-shot. Every result transaction also
// reports the earliest pending deadline and its period after the command. All
// slot reads go through one memory read port, one slot per cycle, into a single
// shared compare unit, so a command costs one or two full scans of the table:
// an add walks the valid bits to find a free slot or see that the table is
// full, then runs a summary scan, while remove and tick run two scans with an
// update step between them, plus a re-arm write when a periodic timer fires.
// The request side is ready only while the sequencer is idle; a finished result
// waits in an output register, so the next request can be taken before the
// previous result has been read.
// ----------------------------------------------------------------------------
module timer_expiry_queue_unit #(
   parameter int SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [teq_pkg::CMD_W-1:0]     req_cmd,
   input  logic [teq_pkg::TIME_W-1:0]    req_deadline,
   input  logic [teq_pkg::TIME_W-1:0]    req_period,
   input  logic [teq_pkg::ID_W-1:0]      req_target_id,
   input  logic [teq_pkg::HND_W-1:0]     req_event_handle,
   input  logic [teq_pkg::TIME_W-1:0]    req_now,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_status,
   output logic [teq_pkg::ID_W-1:0]      rsp_assigned_id,
   output logic                          rsp_fired,
   output logic [teq_pkg::ID_W-1:0]      rsp_fired_id,
   output logic [teq_pkg::HND_W-1:0]     rsp_fired_handle,
   output logic                          rsp_armed,
   output logic [teq_pkg::TIME_W-1:0]    rsp_next_deadline,
   output logic [teq_pkg::TIME_W-1:0]    rsp_next_period
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int SLOT_W = $bits(teq_pkg::slot_type);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOTS);

   // Sequencer states.
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_FREE  = 7'b0000010,
      ST_SCAN1 = 7'b0000100,
      ST_ACT   = 7'b0001000,
      ST_REARM = 7'b0010000,
      ST_SCAN2 = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Latched request.
   logic [teq_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [teq_pkg::TIME_W-1:0] deadline_ff, deadline_in;
   logic [teq_pkg::TIME_W-1:0] period_ff, period_in;
   logic [teq_pkg::ID_W-1:0]   target_ff, target_in;
   logic [teq_pkg::HND_W-1:0]  handle_ff, handle_in;
   logic [teq_pkg::TIME_W-1:0] now_ff, now_in;

   // Per-command results gathered before the summary scan.
   logic                       status_ff, status_in;
   logic [teq_pkg::ID_W-1:0]   assigned_ff, assigned_in;
   logic                       fired_ff, fired_in;
   logic [teq_pkg::ID_W-1:0]   fid_ff, fid_in;
   logic [teq_pkg::HND_W-1:0]  fh_ff, fh_in;

   // Table state.
   logic [SLOTS-1:0]           valid_ff, valid_in;
   logic [teq_pkg::ID_W-1:0]   id_cnt_ff, id_cnt_in;
   logic [teq_pkg::ORD_W-1:0]  ord_cnt_ff, ord_cnt_in;

   // Scan pipeline: the issue counter runs one slot ahead of the read data.
   logic [CNT_W-1:0]           issue_cnt_ff, issue_cnt_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]           rd_idx_ff, rd_idx_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       o_status_ff, o_status_in;
   logic [teq_pkg::ID_W-1:0]   o_assigned_ff, o_assigned_in;
   logic                       o_fired_ff, o_fired_in;
   logic [teq_pkg::ID_W-1:0]   o_fid_ff, o_fid_in;
   logic [teq_pkg::HND_W-1:0]  o_fh_ff, o_fh_in;
   logic                       o_armed_ff, o_armed_in;
   logic [teq_pkg::TIME_W-1:0] o_ndl_ff, o_ndl_in;
   logic [teq_pkg::TIME_W-1:0] o_nper_ff, o_nper_in;

   // Memory and scan unit connections.
   logic                       ram_wr_en;
   logic [IDX_W-1:0]           ram_wr_addr;
   teq_pkg::slot_type          ram_wr_data;
   logic                       ram_rd_en;
   logic [SLOT_W-1:0]          ram_rd_data;
   teq_pkg::slot_type          cand;
   teq_pkg::scan_ctl_type      scan_ctl;
   logic                       best_found;
   logic [IDX_W-1:0]           best_idx;
   teq_pkg::slot_type          best;

   logic                       scanning;
   logic                       scan_done;
   logic                       req_fire;
   logic [teq_pkg::TIME_W:0]   rearm_sum;
   logic [teq_pkg::TIME_W-1:0] rearm_dl;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign scanning  = (state_ff == ST_SCAN1) || (state_ff == ST_SCAN2);
   assign ram_rd_en = scanning && (issue_cnt_ff != CNT_END);
   assign scan_done = scanning && !ram_rd_en && !rd_vld_ff;
   assign cand      = teq_pkg::slot_type'(ram_rd_data);

   // Re-arm deadline saturates at the top of the time range.
   assign rearm_sum = {1'b0, now_ff} + {1'b0, best.period};
   assign rearm_dl  = rearm_sum[teq_pkg::TIME_W] ? '1 : rearm_sum[teq_pkg::TIME_W-1:0];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      deadline_in   = deadline_ff;
      period_in     = period_ff;
      target_in     = target_ff;
      handle_in     = handle_ff;
      now_in        = now_ff;
      status_in     = status_ff;
      assigned_in   = assigned_ff;
      fired_in      = fired_ff;
      fid_in        = fid_ff;
      fh_in         = fh_ff;
      valid_in      = valid_ff;
      id_cnt_in     = id_cnt_ff;
      ord_cnt_in    = ord_cnt_ff;
      issue_cnt_in  = issue_cnt_ff;
      rd_vld_in     = ram_rd_en;
      rd_idx_in     = issue_cnt_ff[IDX_W-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      o_status_in   = o_status_ff;
      o_assigned_in = o_assigned_ff;
      o_fired_in    = o_fired_ff;
      o_fid_in      = o_fid_ff;
      o_fh_in       = o_fh_ff;
      o_armed_in    = o_armed_ff;
      o_ndl_in      = o_ndl_ff;
      o_nper_in     = o_nper_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = issue_cnt_ff[IDX_W-1:0];
      ram_wr_data   = '{deadline: deadline_ff, period: period_ff,
                        id: id_cnt_ff + 1'b1, handle: handle_ff, order: ord_cnt_ff};
      scan_ctl.clr      = 1'b0;
      scan_ctl.cand_vld = rd_vld_ff;
      scan_ctl.match_id = (state_ff == ST_SCAN1) && (cmd_ff == teq_pkg::CMD_REMOVE);

      if (scanning && ram_rd_en) begin
         issue_cnt_in = issue_cnt_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in       = req_cmd;
               deadline_in  = req_deadline;
               period_in    = req_period;
               target_in    = req_target_id;
               handle_in    = req_event_handle;
               now_in       = req_now;
               status_in    = 1'b0;
               assigned_in  = '0;
               fired_in     = 1'b0;
               fid_in       = '0;
               fh_in        = '0;
               issue_cnt_in = '0;
               scan_ctl.clr = 1'b1;
               case (req_cmd)
                  teq_pkg::CMD_ADD:    state_in = ST_FREE;
                  teq_pkg::CMD_REMOVE: state_in = ST_SCAN1;
                  teq_pkg::CMD_TICK:   state_in = ST_SCAN1;
                  default:             state_in = ST_SCAN2;
               endcase
            end
         end
         ST_FREE: begin
            // Walk the valid bits from slot 0 for the lowest free slot.
            if (issue_cnt_ff == CNT_END) begin
               status_in    = 1'b1;
               issue_cnt_in = '0;
               scan_ctl.clr = 1'b1;
               state_in     = ST_SCAN2;
            end else if (!valid_ff[issue_cnt_ff[IDX_W-1:0]]) begin
               ram_wr_en    = 1'b1;
               valid_in[issue_cnt_ff[IDX_W-1:0]] = 1'b1;
               id_cnt_in    = id_cnt_ff + 1'b1;
               ord_cnt_in   = ord_cnt_ff + 1'b1;
               assigned_in  = id_cnt_ff + 1'b1;
               issue_cnt_in = '0;
               scan_ctl.clr = 1'b1;
               state_in     = ST_SCAN2;
            end else begin
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
         end
         ST_SCAN1: begin
            if (scan_done) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            issue_cnt_in = '0;
            scan_ctl.clr = 1'b1;
            state_in     = ST_SCAN2;
            case (cmd_ff)
               teq_pkg::CMD_REMOVE: begin
                  if (best_found) begin
                     valid_in[best_idx] = 1'b0;
                  end
               end
               teq_pkg::CMD_TICK: begin
                  if (best_found && now_ff >= best.deadline) begin
                     fired_in = 1'b1;
                     fid_in   = best.id;
                     fh_in    = best.handle;
                     if (best.period != '0) begin
                        // Keep the scan result intact for the re-arm write.
                        scan_ctl.clr = 1'b0;
                        state_in     = ST_REARM;
                     end else begin
                        valid_in[best_idx] = 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_REARM: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = best_idx;
            ram_wr_data  = '{deadline: rearm_dl, period: best.period, id: best.id,
                             handle: best.handle, order: ord_cnt_ff};
            ord_cnt_in   = ord_cnt_ff + 1'b1;
            issue_cnt_in = '0;
            scan_ctl.clr = 1'b1;
            state_in     = ST_SCAN2;
         end
         ST_SCAN2: begin
            if (scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Publish once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               o_status_in   = status_ff;
               o_assigned_in = assigned_ff;
               o_fired_in    = fired_ff;
               o_fid_in      = fid_ff;
               o_fh_in       = fh_ff;
               o_armed_in    = best_found;
               o_ndl_in      = best_found ? best.deadline : '0;
               o_nper_in     = best_found ? best.period : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         id_cnt_ff    <= '0;
         ord_cnt_ff   <= '0;
         issue_cnt_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         id_cnt_ff    <= id_cnt_in;
         ord_cnt_ff   <= ord_cnt_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      deadline_ff   <= deadline_in;
      period_ff     <= period_in;
      target_ff     <= target_in;
      handle_ff     <= handle_in;
      now_ff        <= now_in;
      status_ff     <= status_in;
      assigned_ff   <= assigned_in;
      fired_ff      <= fired_in;
      fid_ff        <= fid_in;
      fh_ff         <= fh_in;
      rd_idx_ff     <= rd_idx_in;
      o_status_ff   <= o_status_in;
      o_assigned_ff <= o_assigned_in;
      o_fired_ff    <= o_fired_in;
      o_fid_ff      <= o_fid_in;
      o_fh_ff       <= o_fh_in;
      o_armed_ff    <= o_armed_in;
      o_ndl_ff      <= o_ndl_in;
      o_nper_ff     <= o_nper_in;
   end

   teq_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (SLOT_W'(ram_wr_data)),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   teq_scan #(
      .SLOTS (SLOTS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .target_id  (target_ff),
      .cand       (cand),
      .cand_live  (valid_ff[rd_idx_ff]),
      .cand_idx   (rd_idx_ff),
      .best_found (best_found),
      .best_idx   (best_idx),
      .best       (best)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = o_status_ff;
   assign rsp_assigned_id   = o_assigned_ff;
   assign rsp_fired         = o_fired_ff;
   assign rsp_fired_id      = o_fid_ff;
   assign rsp_fired_handle  = o_fh_ff;
   assign rsp_armed         = o_armed_ff;
   assign rsp_next_deadline = o_ndl_ff;
   assign rsp_next_period   = o_nper_ff;

   // An accepted request always starts the sequencer.
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   // A new result is only published from the final state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result published outside the final state");

   // Re-arm only follows the tick update cycle.
   a_rearm_after_act: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REARM |-> $past(state_ff == ST_ACT))
      else $error("re-arm entered out of sequence");

   // The scan issue counter never runs past the table.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scanning |-> issue_cnt_ff <= CNT_END)
      else $error("scan counter past the last slot");

   // A fired timer never comes with a refused add.
   a_fire_no_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_fired_ff |-> !o_status_ff)
      else $error("fired and table full reported together");

endmodule
